// File: hdl/rbuf_pkg.sv
// ----------------------------------------------------------------------------
// rbuf_pkg
// Shared types, codes and sizes of the multi-reader ring buffer.
// ----------------------------------------------------------------------------
package rbuf_pkg;

  localparam int RING_DEPTH_DEF  = 1024;
  localparam int NUM_READERS_DEF = 4;
  localparam int MAX_BATCH       = 16;
  localparam int RECORD_BITS     = 64;

  localparam int CMD_BITS  = 2;
  localparam int RID_BITS  = 2;
  localparam int CNT_BITS  = 5;
  localparam int SIZE_BITS = 11;
  localparam int LAG_BITS  = 10;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam int IN_Q_DEPTH  = 4;
  localparam int OUT_Q_DEPTH = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_RING_SIZE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SNAP_LAG  = 2'd1;

  localparam logic [CMD_BITS-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_SNAP  = 2'd2;
  localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd3;

  localparam logic [SIZE_BITS-1:0] RING_SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [CMD_BITS-1:0]    command;
    logic [RID_BITS-1:0]    reader_id;
    logic [CNT_BITS-1:0]    count;
    logic [RECORD_BITS-1:0] write_record;
  } in_item_t;

  typedef struct packed {
    logic [RECORD_BITS-1:0] record_out;
    logic [RID_BITS-1:0]    reader_out;
    logic                   status;
    logic                   last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_REFUSE,
    OP_SNAP,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [RID_BITS-1:0]    reader_id;
    logic [CNT_BITS-1:0]    count;
    logic [RECORD_BITS-1:0] record;
  } op_entry_t;

endpackage

// File: hdl/rbuf_ram.sv
// ----------------------------------------------------------------------------
// rbuf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbuf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/rbuf_fifo.sv
// ----------------------------------------------------------------------------
// rbuf_fifo
// Short register queue with occupancy count.
// ----------------------------------------------------------------------------
module rbuf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           din,
  output logic                       full,
  input  logic                       pop,
  output logic [WIDTH-1:0]           dout,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wr_ptr;
  logic [PTRW-1:0]  rd_ptr;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTRW'(DEPTH-1)) ? '0 : wr_ptr + PTRW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTRW'(DEPTH-1)) ? '0 : rd_ptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: hdl/rbuf_front.sv
// ----------------------------------------------------------------------------
// rbuf_front
// Input side: accept commands, check reader and count, queue operations.
// ----------------------------------------------------------------------------
module rbuf_front #(
  parameter int NUM_READERS = rbuf_pkg::NUM_READERS_DEF
) (
  input  logic                in_valid,
  output logic                in_ready,
  input  rbuf_pkg::in_item_t  in_item,
  input  logic                q_full,
  input  logic                busy,
  output logic                q_push,
  output rbuf_pkg::op_entry_t q_item
);
  import rbuf_pkg::*;

  logic bad_rid;
  logic bad_cnt;
  logic drop;

  assign bad_rid = int'(in_item.reader_id) >= NUM_READERS;
  assign bad_cnt = (in_item.count == '0) || (int'(in_item.count) > MAX_BATCH);

  always_comb begin
    q_item.reader_id = in_item.reader_id;
    q_item.count     = in_item.count;
    q_item.record    = in_item.write_record;
    drop             = 1'b0;
    unique case (in_item.command)
      CMD_WRITE: begin
        q_item.op = OP_WRITE;
      end
      CMD_READ: begin
        q_item.op = (bad_rid || bad_cnt) ? OP_REFUSE : OP_READ;
      end
      CMD_SNAP: begin
        q_item.op = OP_SNAP;
        drop      = bad_rid;
      end
      default: begin
        q_item.op = OP_CLEAR;
      end
    endcase
  end

  assign in_ready = !q_full && !busy;
  assign q_push   = in_valid && in_ready && !drop;

endmodule

// File: hdl/rbuf_mod.sv
// ----------------------------------------------------------------------------
// rbuf_mod
// Bit-serial remainder unit: one restoring step per cycle.
// ----------------------------------------------------------------------------
module rbuf_mod #(
  parameter int RING_DEPTH = rbuf_pkg::RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [((($clog2(RING_DEPTH)) > rbuf_pkg::LAG_BITS) ?
                 $clog2(RING_DEPTH) : rbuf_pkg::LAG_BITS)-1:0] dividend,
  input  logic [$clog2(RING_DEPTH+1)-1:0]     divisor,
  output logic                                done,
  output logic [$clog2(RING_DEPTH)-1:0]       remainder
);
  import rbuf_pkg::*;

  localparam int PW   = $clog2(RING_DEPTH);
  localparam int SW   = $clog2(RING_DEPTH+1);
  localparam int DW   = (PW > LAG_BITS) ? PW : LAG_BITS;
  localparam int CNTW = $clog2(DW+1);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [DW-1:0]   shreg;
  logic [SW-1:0]   rem;
  logic [SW:0]     trial;

  assign trial     = {rem, shreg[DW-1]};
  assign remainder = PW'(rem);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CNTW'(DW);
        shreg <= dividend;
        rem   <= '0;
      end else if (run) begin
        rem   <= (trial >= (SW+1)'(divisor)) ? SW'(trial - (SW+1)'(divisor)) : SW'(trial);
        shreg <= shreg << 1;
        cnt   <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: hdl/rbuf_back.sv
// ----------------------------------------------------------------------------
// rbuf_back
// Execution side: ring store, positions, read streaming, config rewrap pass.
// ----------------------------------------------------------------------------
module rbuf_back #(
  parameter int RING_DEPTH  = rbuf_pkg::RING_DEPTH_DEF,
  parameter int NUM_READERS = rbuf_pkg::NUM_READERS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_acc,
  input  logic [rbuf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [rbuf_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                                   q_valid,
  input  rbuf_pkg::op_entry_t                    q_item,
  output logic                                   q_pop,
  input  logic [$clog2(rbuf_pkg::OUT_Q_DEPTH+1)-1:0] o_count,
  output logic                                   o_push,
  output rbuf_pkg::out_item_t                    o_item,
  output logic                                   busy
);
  import rbuf_pkg::*;

  localparam int PW   = $clog2(RING_DEPTH);
  localparam int SW   = $clog2(RING_DEPTH+1);
  localparam int CW   = (SW > SIZE_BITS) ? SW : SIZE_BITS;
  localparam int EW   = ((SW > CNT_BITS) ? SW : CNT_BITS) + 1;
  localparam int DW   = (PW > LAG_BITS) ? PW : LAG_BITS;
  localparam int RW   = (NUM_READERS > 1) ? $clog2(NUM_READERS) : 1;
  localparam int JN   = NUM_READERS + 2;
  localparam int JW   = $clog2(JN);
  localparam int OCW1 = $clog2(OUT_Q_DEPTH+1) + 1;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_STREAM = 3'b010,
    ST_NORM   = 3'b100
  } back_state_t;

  back_state_t           state;
  logic [SIZE_BITS-1:0]  ring_size;
  logic [LAG_BITS-1:0]   snap_lag;
  logic [PW-1:0]         lag_eff;
  logic [PW-1:0]         w_raw;
  logic [PW-1:0]         w_norm;
  logic [PW-1:0]         rd_raw  [NUM_READERS];
  logic [PW-1:0]         rd_norm [NUM_READERS];
  logic [PW-1:0]         addr;
  logic [CNT_BITS-1:0]   remain;
  logic [RID_BITS-1:0]   s_rid;
  logic                  pend_valid;
  logic                  pend_rec;
  logic                  pend_last;
  logic [RID_BITS-1:0]   pend_rid;
  logic                  go;
  logic [JW-1:0]         job;

  logic [CW-1:0]         sz_ext;
  logic [SW-1:0]         sz;
  logic [RW-1:0]         idx;
  logic [RW-1:0]         job_idx;
  logic [EW-1:0]         w_e, r_e, n_e, s_e, lag_e, rn, w_inc, a_inc;
  logic                  granted;
  logic [PW-1:0]         read_end, w_adv, snap_pos, addr_adv;
  logic                  credit;
  logic                  needs_credit;
  logic                  issue;
  logic [DW-1:0]         m_dividend;
  logic                  m_done;
  logic [PW-1:0]         m_rem;
  logic [RECORD_BITS-1:0] ram_q;

  assign sz_ext = CW'(ring_size);

  always_comb begin
    priority if (sz_ext < CW'(2)) begin
      sz = SW'(2);
    end else if (sz_ext > CW'(RING_DEPTH)) begin
      sz = SW'(RING_DEPTH);
    end else begin
      sz = SW'(sz_ext);
    end
  end

  assign idx   = RW'(q_item.reader_id);
  assign w_e   = EW'(w_norm);
  assign r_e   = EW'(rd_norm[idx]);
  assign n_e   = EW'(q_item.count);
  assign s_e   = EW'(sz);
  assign lag_e = EW'(lag_eff);
  assign rn    = r_e + n_e;
  assign w_inc = w_e + EW'(1);
  assign a_inc = EW'(addr) + EW'(1);

  always_comb begin
    priority if (r_e < w_e) begin
      granted = (rn <= w_e);
    end else if (r_e > w_e) begin
      granted = (rn < w_e + s_e);
    end else begin
      granted = 1'b0;
    end
  end

  assign read_end = (rn >= s_e) ? PW'(rn - s_e) : PW'(rn);
  assign w_adv    = (w_inc == s_e) ? '0 : PW'(w_inc);
  assign addr_adv = (a_inc == s_e) ? '0 : PW'(a_inc);
  assign snap_pos = (w_e >= lag_e) ? PW'(w_e - lag_e) : PW'(w_e + s_e - lag_e);

  assign credit       = (OCW1'(o_count) + OCW1'(pend_valid)) < OCW1'(OUT_Q_DEPTH);
  assign needs_credit = (q_item.op == OP_READ) || (q_item.op == OP_REFUSE);
  assign q_pop        = (state == ST_IDLE) && q_valid && (!needs_credit || credit);
  assign issue        = (state == ST_STREAM) && credit;
  assign busy         = (state == ST_NORM);

  assign job_idx = RW'(job - JW'(2));

  always_comb begin
    priority if (job == '0) begin
      m_dividend = DW'(snap_lag);
    end else if (job == JW'(1)) begin
      m_dividend = DW'(w_raw);
    end else begin
      m_dividend = DW'(rd_raw[job_idx]);
    end
  end

  rbuf_mod #(
    .RING_DEPTH (RING_DEPTH)
  ) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (go),
    .dividend  (m_dividend),
    .divisor   (sz),
    .done      (m_done),
    .remainder (m_rem)
  );

  rbuf_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (RING_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (q_pop && (q_item.op == OP_WRITE)),
    .waddr (w_norm),
    .wdata (q_item.record),
    .re    (issue),
    .raddr (addr),
    .rdata (ram_q)
  );

  assign o_push            = pend_valid;
  assign o_item.record_out = pend_rec ? ram_q : '0;
  assign o_item.reader_out = pend_rid;
  assign o_item.status     = !pend_rec;
  assign o_item.last       = pend_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_size  <= RING_SIZE_RESET;
      snap_lag   <= '0;
      lag_eff    <= '0;
      w_raw      <= '0;
      w_norm     <= '0;
      pend_valid <= 1'b0;
      go         <= 1'b0;
      job        <= '0;
      for (int i = 0; i < NUM_READERS; i++) begin
        rd_raw[i]  <= '0;
        rd_norm[i] <= '0;
      end
    end else begin
      go         <= 1'b0;
      pend_valid <= 1'b0;
      if (cfg_acc) begin
        if (cfg_index == REG_RING_SIZE) begin
          ring_size <= cfg_data[SIZE_BITS-1:0];
        end else if (cfg_index == REG_SNAP_LAG) begin
          snap_lag <= cfg_data[LAG_BITS-1:0];
        end
        state <= ST_NORM;
        job   <= '0;
        go    <= 1'b1;
      end else begin
        unique case (state)
          ST_IDLE: begin
            if (q_pop) begin
              unique case (q_item.op)
                OP_WRITE: begin
                  w_raw  <= w_adv;
                  w_norm <= w_adv;
                end
                OP_SNAP: begin
                  rd_raw[idx]  <= snap_pos;
                  rd_norm[idx] <= snap_pos;
                end
                OP_READ: begin
                  if (granted) begin
                    rd_raw[idx]  <= read_end;
                    rd_norm[idx] <= read_end;
                    addr         <= rd_norm[idx];
                    remain       <= q_item.count;
                    s_rid        <= q_item.reader_id;
                    state        <= ST_STREAM;
                  end else begin
                    pend_valid <= 1'b1;
                    pend_rec   <= 1'b0;
                    pend_last  <= 1'b1;
                    pend_rid   <= q_item.reader_id;
                  end
                end
                OP_REFUSE: begin
                  pend_valid <= 1'b1;
                  pend_rec   <= 1'b0;
                  pend_last  <= 1'b1;
                  pend_rid   <= q_item.reader_id;
                end
                default: begin
                  w_raw  <= '0;
                  w_norm <= '0;
                  for (int i = 0; i < NUM_READERS; i++) begin
                    rd_raw[i]  <= '0;
                    rd_norm[i] <= '0;
                  end
                end
              endcase
            end
          end
          ST_STREAM: begin
            if (issue) begin
              pend_valid <= 1'b1;
              pend_rec   <= 1'b1;
              pend_last  <= (remain == CNT_BITS'(1));
              pend_rid   <= s_rid;
              addr       <= addr_adv;
              remain     <= remain - CNT_BITS'(1);
              if (remain == CNT_BITS'(1)) begin
                state <= ST_IDLE;
              end
            end
          end
          default: begin
            if (m_done && !go) begin
              priority if (job == '0) begin
                lag_eff <= m_rem;
              end else if (job == JW'(1)) begin
                w_norm <= m_rem;
              end else begin
                rd_norm[job_idx] <= m_rem;
              end
              if (job == JW'(JN-1)) begin
                state <= ST_IDLE;
              end else begin
                job <= job + JW'(1);
                go  <= 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

endmodule

// File: hdl/multi_reader_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// multi_reader_ring_buffer_top
// Ring store with one writer and several independent readers.
// ----------------------------------------------------------------------------
// Channel  Role    Handshake             Payload
// in       sink    in_valid / in_ready   in_item  (command, reader, count, record)
// out      source  out_valid / out_ready out_item (record, reader, status, last)
// cfg      sink    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Write, snap and clear each run in the execution stage. Read: an availability
// check, then one record per cycle from the ring store read port while the
// output queue has room. A config write starts a rewrap pass in the serial
// remainder unit; input is held.
// Reset needs no clearing pass; the store holds no data until written.
// A four-entry queue on each side lets input and output stall independently.
// ----------------------------------------------------------------------------
module multi_reader_ring_buffer_top #(
  parameter int RING_DEPTH  = rbuf_pkg::RING_DEPTH_DEF,
  parameter int NUM_READERS = rbuf_pkg::NUM_READERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rbuf_pkg::in_item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rbuf_pkg::out_item_t                 out_item,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbuf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rbuf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rbuf_pkg::*;

  op_entry_t  f_item;
  op_entry_t  q_item;
  out_item_t  o_item;
  logic       f_push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  logic       busy;
  logic       o_push;
  logic       o_empty;
  logic [$clog2(IN_Q_DEPTH+1)-1:0]  q_count;
  logic [$clog2(OUT_Q_DEPTH+1)-1:0] o_count;

  assign cfg_ready = 1'b1;

  rbuf_front #(
    .NUM_READERS (NUM_READERS)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .busy     (busy),
    .q_push   (f_push),
    .q_item   (f_item)
  );

  rbuf_fifo #(
    .WIDTH ($bits(op_entry_t)),
    .DEPTH (IN_Q_DEPTH)
  ) u_op_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .din   (f_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty),
    .count (q_count)
  );

  rbuf_back #(
    .RING_DEPTH  (RING_DEPTH),
    .NUM_READERS (NUM_READERS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_acc   (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (!q_empty && (q_count != '0)),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .o_count   (o_count),
    .o_push    (o_push),
    .o_item    (o_item),
    .busy      (busy)
  );

  rbuf_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   (o_item),
    .full  (),
    .pop   (out_valid && out_ready),
    .dout  (out_item),
    .empty (o_empty),
    .count (o_count)
  );

  assign out_valid = !o_empty;

endmodule

// File: hdl/rbuf_checker.sv
// ----------------------------------------------------------------------------
// rbuf_checker
// Port-level checks of the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rbuf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input rbuf_pkg::in_item_t                  in_item,
  input logic                                out_valid,
  input logic                                out_ready,
  input rbuf_pkg::out_item_t                 out_item,
  input logic                                cfg_valid,
  input logic                                cfg_ready,
  input logic [rbuf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input logic [rbuf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  a_refuse_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.last)
    else $error("refusal without last");

  a_refuse_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.status |-> out_item.record_out == '0)
    else $error("refusal carries a record");

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input taken during rewrap pass");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled output changed");

endmodule

bind multi_reader_ring_buffer_top rbuf_checker u_rbuf_checker (.*);

// File: test/tb_multi_reader_ring_buffer_top.sv
// ----------------------------------------------------------------------------
// tb_multi_reader_ring_buffer_top
// Self-checking bench for the multi-reader ring buffer. A directed table runs
// through refusals, batch reads, snaps, clears, stale positions and ring sizes
// out of range. Random phases with fresh settings follow. Every word from
// the block is compared field by field against a predicted ring.
// ----------------------------------------------------------------------------
module tb_multi_reader_ring_buffer_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rbuf_pkg::*;

  localparam int  DEPTH           = RING_DEPTH_DEF;
  localparam int  READERS         = NUM_READERS_DEF;
  localparam int  IDLE_SETTLE     = 100;
  localparam int  N_PHASES        = 6;
  localparam int  ITEMS_PER_PHASE = 16;
  localparam      LIMIT_NS        = 1000000;
  localparam logic ST_DELIVERED   = 1'b0;
  localparam logic ST_REFUSED     = 1'b1;

  typedef enum {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                 kind;
    in_item_t                  word;
    bit                        typed;
    out_item_t                 want;
    logic [CFG_INDEX_BITS-1:0] idx;
    logic [CFG_DATA_BITS-1:0]  data;
  } plan_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_item = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_item;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  logic [RECORD_BITS-1:0] ring_mem [DEPTH];
  bit                     ring_written [DEPTH];
  int                     wr_ptr;
  int                     rd_ptr [READERS];
  logic [SIZE_BITS-1:0]   size_reg = RING_SIZE_RESET;
  logic [LAG_BITS-1:0]    lag_reg = '0;

  out_item_t due_records[$];
  plan_row_t plan[$];
  bit        calm = 1'b0;
  int        error_count = 0;
  int        words_sent = 0;
  int        records_seen = 0;
  int        refusals_seen = 0;
  int        reg_writes = 0;

  multi_reader_ring_buffer_top uut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #1 clk = ~clk;

  function automatic int eff_size();
    int s;
    s = int'(size_reg);
    if (s < 2) s = 2;
    if (s > DEPTH) s = DEPTH;
    return s;
  endfunction

  function automatic int granted_len(logic [RID_BITS-1:0] rid, int n);
    int sz, w, r;
    sz = eff_size();
    w  = wr_ptr % sz;
    r  = rd_ptr[rid] % sz;
    if (n == 0 || n > MAX_BATCH) return 0;
    if (r < w) return (r + n <= w) ? n : 0;
    if (r > w) return (r + n < w + sz) ? n : 0;
    return 0;
  endfunction

  function automatic bit span_written(int r, int n);
    int sz;
    sz = eff_size();
    for (int k = 0; k < n; k++)
      if (!ring_written[(r + k) % sz]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void run_command(in_item_t w);
    int sz, wp, r, n;
    sz = eff_size();
    wp = wr_ptr % sz;
    unique case (w.command)
      CMD_WRITE: begin
        ring_mem[wp]     = w.write_record;
        ring_written[wp] = 1'b1;
        wr_ptr           = (wp + 1) % sz;
      end
      CMD_READ: begin
        n = granted_len(w.reader_id, int'(w.count));
        if (n == 0) begin
          due_records.push_back('{'0, w.reader_id, ST_REFUSED, 1'b1});
        end else begin
          r = rd_ptr[w.reader_id] % sz;
          for (int k = 0; k < n; k++)
            due_records.push_back('{ring_mem[(r + k) % sz], w.reader_id, ST_DELIVERED,
                                    (k == n - 1)});
          rd_ptr[w.reader_id] = (r + n) % sz;
        end
      end
      CMD_SNAP: begin
        rd_ptr[w.reader_id] = (wp + sz - (lag_reg % sz)) % sz;
      end
      default: begin
        wr_ptr = 0;
        foreach (rd_ptr[i]) rd_ptr[i] = 0;
      end
    endcase
  endfunction

  function automatic in_item_t next_command();
    in_item_t    w;
    logic [95:0] raw;
    int roll, sz, wp, rp, avail;
    raw  = {$urandom, $urandom, $urandom};
    w    = raw[$bits(in_item_t)-1:0];
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      w.command = CMD_WRITE;
    end else if (roll < 85) begin
      w.command = CMD_READ;
      sz    = eff_size();
      wp    = wr_ptr % sz;
      rp    = rd_ptr[w.reader_id] % sz;
      avail = (rp < wp) ? wp - rp : (rp > wp) ? wp + sz - rp - 1 : 0;
      if (avail > MAX_BATCH) avail = MAX_BATCH;
      if (avail > 0 && $urandom_range(0, 5) != 0)
        w.count = CNT_BITS'($urandom_range(1, avail));
      if (granted_len(w.reader_id, int'(w.count)) != 0 && !span_written(rp, int'(w.count)))
        w.command = CMD_WRITE;
    end else if (roll < 97) begin
      w.command = CMD_SNAP;
    end else begin
      w.command = CMD_CLEAR;
    end
    return w;
  endfunction

  function automatic int pick_gap();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic void add_word(logic [CMD_BITS-1:0] cmd, logic [RID_BITS-1:0] rid,
                                   logic [CNT_BITS-1:0] cnt, logic [RECORD_BITS-1:0] rec);
    plan_row_t p;
    p       = '{kind: ROW_WORD, typed: 1'b0, want: '0, idx: '0, data: '0, word: '0};
    p.word  = '{cmd, rid, cnt, rec};
    plan.push_back(p);
  endfunction

  function automatic void add_probe(logic [RID_BITS-1:0] rid, logic [CNT_BITS-1:0] cnt,
                                    logic [RECORD_BITS-1:0] rec, logic st);
    plan_row_t p;
    p       = '{kind: ROW_WORD, typed: 1'b1, want: '0, idx: '0, data: '0, word: '0};
    p.word  = '{CMD_READ, rid, cnt, 64'h0};
    p.want  = '{rec, rid, st, 1'b1};
    plan.push_back(p);
  endfunction

  function automatic void add_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                  logic [CFG_DATA_BITS-1:0] data);
    plan.push_back('{kind: ROW_CFG, word: '0, typed: 1'b0, want: '0, idx: idx, data: data});
  endfunction

  task automatic send_word(in_item_t w, bit typed, out_item_t want);
    int gap, depth;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    do @(posedge clk); while (!in_ready);
    depth = due_records.size();
    run_command(w);
    if (typed) begin
      while (due_records.size() > depth) void'(due_records.pop_back());
      due_records.push_back(want);
    end
    words_sent++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    in_valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RING_SIZE) size_reg = data[SIZE_BITS-1:0];
    else if (idx == REG_SNAP_LAG) lag_reg = data[LAG_BITS-1:0];
    cfg_valid <= 1'b0;
    reg_writes++;
  endtask

  initial begin
    out_item_t want;
    int        gap;
    while (rst) @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (out_item.status === ST_REFUSED) refusals_seen++;
      else records_seen++;
      if (due_records.size() == 0) begin
        $error("unexpected word: record %h reader %0d status %b last %b",
               out_item.record_out, out_item.reader_out, out_item.status, out_item.last);
        error_count++;
      end else begin
        want = due_records.pop_front();
        if (out_item.record_out !== want.record_out) begin
          $error("record_out: expected %h, got %h", want.record_out, out_item.record_out);
          error_count++;
        end
        if (out_item.reader_out !== want.reader_out) begin
          $error("reader_out: expected %0d, got %0d", want.reader_out, out_item.reader_out);
          error_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %b, got %b", want.status, out_item.status);
          error_count++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [CFG_DATA_BITS-1:0] size_data, lag_data;

    wr_ptr = 0;
    foreach (rd_ptr[i]) rd_ptr[i] = 0;
    foreach (ring_written[i]) ring_written[i] = 1'b0;

    add_probe(2'd0, 5'd1, 64'h0, ST_REFUSED);
    add_probe(2'd1, 5'd0, 64'h0, ST_REFUSED);
    add_word(CMD_WRITE, 2'd0, 5'd0, 64'h0);
    add_word(CMD_WRITE, 2'd3, 5'd31, 64'hFFFF_FFFF_FFFF_FFFF);
    add_word(CMD_WRITE, 2'd1, 5'd16, 64'hA5A5_A5A5_A5A5_A5A5);
    add_word(CMD_WRITE, 2'd2, 5'd1, 64'h5A5A_5A5A_5A5A_5A5A);
    add_probe(2'd0, 5'd31, 64'h0, ST_REFUSED);
    add_probe(2'd1, 5'd17, 64'h0, ST_REFUSED);
    add_probe(2'd0, 5'd1, 64'h0, ST_DELIVERED);
    add_word(CMD_READ, 2'd0, 5'd3, 64'hFFFF_FFFF_FFFF_FFFF);
    add_probe(2'd0, 5'd1, 64'h0, ST_REFUSED);
    add_word(CMD_SNAP, 2'd2, 5'd0, 64'h0);
    add_probe(2'd2, 5'd1, 64'h0, ST_REFUSED);
    add_word(CMD_WRITE, 2'd0, 5'd0, 64'h0123_4567_89AB_CDEF);
    add_word(CMD_READ, 2'd3, 5'd5, 64'h0);
    add_reg(REG_RING_SIZE, 16'd4);
    add_reg(REG_SNAP_LAG, 16'd1023);
    add_word(CMD_READ, 2'd0, 5'd1, 64'h0);
    add_word(CMD_READ, 2'd3, 5'd1, 64'h0);
    add_word(CMD_WRITE, 2'd1, 5'd2, 64'hFEDC_BA98_7654_3210);
    add_word(CMD_SNAP, 2'd1, 5'd0, 64'h0);
    add_word(CMD_READ, 2'd1, 5'd2, 64'h0);
    add_word(CMD_CLEAR, 2'd0, 5'd0, 64'h0);
    add_probe(2'd3, 5'd1, 64'h0, ST_REFUSED);
    add_reg(REG_RING_SIZE, 16'd0);
    add_reg(REG_SNAP_LAG, 16'd5);
    add_word(CMD_WRITE, 2'd0, 5'd0, 64'h3C3C_3C3C_C3C3_C3C3);
    add_word(CMD_SNAP, 2'd0, 5'd0, 64'h0);
    add_word(CMD_READ, 2'd0, 5'd1, 64'h0);
    add_reg(REG_RING_SIZE, 16'hFFFF);
    add_reg(REG_SNAP_LAG, 16'hFFFF);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
      else send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      if (phase > 0) begin
        case ($urandom_range(0, 5))
          0:       size_data = 16'd2;
          1:       size_data = CFG_DATA_BITS'($urandom_range(3, 8));
          2:       size_data = CFG_DATA_BITS'($urandom_range(9, 40));
          3:       size_data = 16'd1024;
          4:       size_data = CFG_DATA_BITS'($urandom_range(0, 1));
          default: size_data = CFG_DATA_BITS'($urandom_range(1025, 16'hFFFF));
        endcase
        case ($urandom_range(0, 3))
          0:       lag_data = 16'd0;
          1:       lag_data = 16'd1023;
          2:       lag_data = CFG_DATA_BITS'($urandom_range(0, 1023));
          default: lag_data = CFG_DATA_BITS'($urandom_range(0, 16'hFFFF));
        endcase
        write_reg(REG_RING_SIZE, size_data);
        write_reg(REG_SNAP_LAG, lag_data);
      end
      calm = (phase % 3 == 2);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_word(next_command(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (due_records.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);

    $display("Sent %0d commands across %0d register writes and %0d random phases.",
             words_sent, reg_writes, N_PHASES);
    $display("Checked %0d delivered records and %0d refusals.", records_seen, refusals_seen);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
